// ----- hdl/sdwq_pkg.sv -----
`timescale 1ns / 1ps

package sdwq_pkg;

  localparam int SLOT_W = 64;
  localparam int TIME_W = 64;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic signed [TIME_W-1:0] due_t;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  localparam slot_t SLOT_MAX = '1;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_ADD_CHK = 9'b000000010,
    ST_NXT_CHK = 9'b000000100,
    ST_INDEX   = 9'b000001000,
    ST_FILL    = 9'b000010000,
    ST_UPD_RD  = 9'b000100000,
    ST_UPD_WR  = 9'b001000000,
    ST_SCAN    = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    ADD_EMPTY  = 2'd0,
    ADD_DOWN   = 2'd1,
    ADD_UP     = 2'd2,
    ADD_INSIDE = 2'd3
  } add_kind_t;

endpackage

// ----- hdl/sdwq_ram.sv -----
`timescale 1ns / 1ps

module sdwq_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/slot_deadline_window_queue_core.sv -----
`timescale 1ns / 1ps
// Sequence: an add is checked, the ring indexed, then N entries written (N = 1..RING_DEPTH-1);
//   a slot inside the window is read and kept or rewritten instead; a next is indexed, then scans
//   until an entry is due or the window ends; a refused add or a next whose cursor lies past the
//   window goes straight to the result. Throughput: one transaction at a time, the next accepted
//   only after the result loads; the walk covers one entry per cycle over the deadline RAM port.
// Reset (rst, synchronous): window, ring head and watermark clear, output empty; RAM not cleared.

module slot_deadline_window_queue_core #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_wr_en,
  input  logic [63:0]             cfg_wr_data,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    command,
  input  logic [63:0]             slot_number,
  input  logic signed [63:0]      due_time,
  input  logic signed [63:0]      current_time,
  input  logic [63:0]             scan_cursor,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [63:0]             ready_slot,
  output logic                    overrun,
  output logic [63:0]             head_slot
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int REM_W = IDX_W + 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  localparam logic [REM_W-1:0]        DEPTH_R  = REM_W'(RING_DEPTH);
  localparam sdwq_pkg::slot_t         DEPTH_S  = sdwq_pkg::SLOT_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]        CNT_ONE  = CNT_W'(1);

  sdwq_pkg::state_t    state;
  sdwq_pkg::add_kind_t add_kind;

  // Window bounds and configuration.
  sdwq_pkg::slot_t low_watermark;
  sdwq_pkg::slot_t window_start;
  sdwq_pkg::slot_t window_end;

  // Ring index of window_start. The window never spans more than the ring, so every slot
  // in it sits at its offset from the head, wrapped once; an empty window keeps any head.
  logic [IDX_W-1:0] head_idx;
  logic [IDX_W-1:0] off_q;
  logic             off_back;

  // Captured request.
  logic             cmd_q;
  sdwq_pkg::slot_t  slot_q;
  sdwq_pkg::due_t   due_q;
  sdwq_pkg::due_t   now_q;
  sdwq_pkg::slot_t  cursor_q;

  // Ring walk.
  logic [IDX_W-1:0] ring_idx;
  logic [CNT_W-1:0] cnt;
  logic             fill_first;
  sdwq_pkg::slot_t  scan_slot;
  logic             ev_valid;
  sdwq_pkg::slot_t  ev_slot;
  logic [IDX_W-1:0] ev_idx;

  // Result being built.
  logic             res_found;
  sdwq_pkg::slot_t  res_slot;
  logic             res_overrun;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [63:0]      ram_wdata;
  logic [63:0]      ram_rdata;

  sdwq_ram #(
    .WIDTH  (64),
    .DEPTH  (RING_DEPTH),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ring_idx),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == sdwq_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Add classification: where the slot falls against the current window.
  // ---------------------------------------------------------------------------
  logic                win_empty;
  sdwq_pkg::slot_t     dn_span;
  sdwq_pkg::slot_t     up_span;
  sdwq_pkg::add_kind_t kind_now;
  logic                add_ovr;

  assign win_empty = (window_start == window_end);
  assign dn_span   = window_end - slot_q;
  assign up_span   = slot_q - window_start;

  always_comb begin
    if (win_empty) begin
      kind_now = sdwq_pkg::ADD_EMPTY;
    end else if (slot_q < window_start) begin
      kind_now = sdwq_pkg::ADD_DOWN;
    end else if (slot_q >= window_end) begin
      kind_now = sdwq_pkg::ADD_UP;
    end else begin
      kind_now = sdwq_pkg::ADD_INSIDE;
    end
  end

  always_comb begin
    case (kind_now)
      sdwq_pkg::ADD_EMPTY:  add_ovr = (slot_q == sdwq_pkg::SLOT_MAX);
      sdwq_pkg::ADD_DOWN:   add_ovr = (dn_span > DEPTH_S);
      sdwq_pkg::ADD_UP:     add_ovr = (slot_q == sdwq_pkg::SLOT_MAX) || (up_span >= DEPTH_S);
      default:              add_ovr = 1'b0;
    endcase
  end

  // Scan start for next: the later of cursor and window head.
  sdwq_pkg::slot_t scan_from;
  assign scan_from = (cursor_q > window_start) ? cursor_q : window_start;

  // ---------------------------------------------------------------------------
  // Ring index: head plus or minus an offset below the depth, wrapped once.
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0] idx_fwd;
  logic [REM_W-1:0] idx_fwd_wrap;
  logic [REM_W-1:0] idx_back;
  logic [REM_W-1:0] idx_back_wrap;
  logic [IDX_W-1:0] idx_calc;

  assign idx_fwd       = {1'b0, head_idx} + {1'b0, off_q};
  assign idx_fwd_wrap  = idx_fwd - DEPTH_R;
  assign idx_back      = {1'b0, head_idx} - {1'b0, off_q};
  assign idx_back_wrap = idx_back + DEPTH_R;

  always_comb begin
    if (off_back) begin
      idx_calc = (head_idx >= off_q) ? idx_back[IDX_W-1:0] : idx_back_wrap[IDX_W-1:0];
    end else begin
      idx_calc = (idx_fwd >= DEPTH_R) ? idx_fwd_wrap[IDX_W-1:0] : idx_fwd[IDX_W-1:0];
    end
  end

  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] head_inc;
  assign idx_inc  = (ring_idx == IDX_LAST) ? '0 : ring_idx + IDX_W'(1);
  assign head_inc = (head_idx == IDX_LAST) ? '0 : head_idx + IDX_W'(1);

  // ---------------------------------------------------------------------------
  // Scan evaluation of the entry whose read returned this cycle.
  // ---------------------------------------------------------------------------
  logic ev_skip;
  logic ev_due;

  assign ev_skip = ev_valid && ((ev_slot <= low_watermark) || (ram_rdata == '0));
  assign ev_due  = ev_valid && !ev_skip && ($signed(ram_rdata) <= now_q);

  // In-window update keeps the earlier nonzero due time.
  logic upd_take;
  assign upd_take = (ram_rdata == '0) || ($signed(ram_rdata) > due_q);

  // ---------------------------------------------------------------------------
  // RAM write port.
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ring_idx;
    ram_wdata = '0;
    case (state)
      sdwq_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (add_kind == sdwq_pkg::ADD_UP) begin
          // zero fill from the old end, due time on the new slot last
          ram_wdata = (cnt == CNT_ONE) ? due_q : '0;
        end else begin
          // due time on the new slot first, zero fill up to the old head
          ram_wdata = fill_first ? due_q : '0;
        end
      end
      sdwq_pkg::ST_UPD_WR: begin
        ram_we    = upd_take;
        ram_wdata = due_q;
      end
      sdwq_pkg::ST_SCAN: begin
        // clear the entry just found due
        ram_we    = ev_due;
        ram_waddr = ev_idx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control and state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sdwq_pkg::ST_IDLE;
      low_watermark <= '0;
      window_start  <= '0;
      window_end    <= '0;
      head_idx      <= '0;
      out_valid     <= 1'b0;
      ev_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        low_watermark <= cfg_wr_data;
      end

      // drop the result once taken; DONE refills it instead
      if (out_valid && out_ready && (state != sdwq_pkg::ST_DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        sdwq_pkg::ST_IDLE: begin
          if (in_valid) begin
            cmd_q    <= command;
            slot_q   <= slot_number;
            due_q    <= due_time;
            now_q    <= current_time;
            cursor_q <= scan_cursor;
            state    <= (command == sdwq_pkg::CMD_ADD) ? sdwq_pkg::ST_ADD_CHK
                                                       : sdwq_pkg::ST_NXT_CHK;
          end
        end

        sdwq_pkg::ST_ADD_CHK: begin
          res_found   <= 1'b0;
          res_slot    <= '0;
          res_overrun <= add_ovr;
          add_kind    <= kind_now;
          fill_first  <= 1'b1;
          // walk from the new slot when growing down (back from the head), from the old
          // end when growing up, from the slot itself inside, from the head when empty
          off_back    <= (kind_now == sdwq_pkg::ADD_DOWN);
          case (kind_now)
            sdwq_pkg::ADD_DOWN: begin
              cnt   <= CNT_W'(window_start - slot_q);
              off_q <= IDX_W'(window_start - slot_q);
            end
            sdwq_pkg::ADD_UP: begin
              cnt   <= CNT_W'(slot_q - window_end + 64'd1);
              off_q <= IDX_W'(window_end - window_start);
            end
            sdwq_pkg::ADD_INSIDE: begin
              cnt   <= CNT_ONE;
              off_q <= IDX_W'(up_span);
            end
            default: begin
              cnt   <= CNT_ONE;
              off_q <= '0;
            end
          endcase
          if (add_ovr) begin
            state <= sdwq_pkg::ST_DONE;
          end else begin
            case (kind_now)
              sdwq_pkg::ADD_EMPTY: begin
                window_start <= slot_q;
                window_end   <= slot_q + 64'd1;
              end
              sdwq_pkg::ADD_DOWN: window_start <= slot_q;
              sdwq_pkg::ADD_UP:   window_end   <= slot_q + 64'd1;
              default: begin
                window_start <= window_start;
              end
            endcase
            state <= sdwq_pkg::ST_INDEX;
          end
        end

        sdwq_pkg::ST_NXT_CHK: begin
          res_found   <= 1'b0;
          res_slot    <= '0;
          res_overrun <= 1'b0;
          off_back    <= 1'b0;
          off_q       <= IDX_W'(scan_from - window_start);
          scan_slot   <= scan_from;
          ev_valid    <= 1'b0;
          // cursor at or past the end: nothing to scan, nothing changes
          state <= (scan_from >= window_end) ? sdwq_pkg::ST_DONE : sdwq_pkg::ST_INDEX;
        end

        sdwq_pkg::ST_INDEX: begin
          ring_idx <= idx_calc;
          if (cmd_q == sdwq_pkg::CMD_NEXT) begin
            state <= sdwq_pkg::ST_SCAN;
          end else if (add_kind == sdwq_pkg::ADD_INSIDE) begin
            state <= sdwq_pkg::ST_UPD_RD;
          end else begin
            // growing down moves the head back to the new slot
            if (add_kind == sdwq_pkg::ADD_DOWN) begin
              head_idx <= idx_calc;
            end
            state <= sdwq_pkg::ST_FILL;
          end
        end

        sdwq_pkg::ST_FILL: begin
          ring_idx   <= idx_inc;
          cnt        <= cnt - CNT_ONE;
          fill_first <= 1'b0;
          if (cnt == CNT_ONE) begin
            state <= sdwq_pkg::ST_DONE;
          end
        end

        sdwq_pkg::ST_UPD_RD: begin
          // read issued at ring_idx; data returns next cycle
          state <= sdwq_pkg::ST_UPD_WR;
        end

        sdwq_pkg::ST_UPD_WR: begin
          state <= sdwq_pkg::ST_DONE;
        end

        sdwq_pkg::ST_SCAN: begin
          // pop the head when the evaluated entry is empty, useless or taken
          if ((ev_skip || ev_due) && (window_start == ev_slot)) begin
            window_start <= ev_slot + 64'd1;
            head_idx     <= head_inc;
          end
          if (ev_due) begin
            res_found <= 1'b1;
            res_slot  <= ev_slot;
            ev_valid  <= 1'b0;
            state     <= sdwq_pkg::ST_DONE;
          end else if (scan_slot < window_end) begin
            // issue the next read while evaluating this one
            ev_valid  <= 1'b1;
            ev_slot   <= scan_slot;
            ev_idx    <= ring_idx;
            scan_slot <= scan_slot + 64'd1;
            ring_idx  <= idx_inc;
          end else begin
            ev_valid <= 1'b0;
            if (!ev_valid) begin
              state <= sdwq_pkg::ST_DONE;
            end
          end
        end

        sdwq_pkg::ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            found      <= res_found;
            ready_slot <= res_slot;
            overrun    <= res_overrun;
            head_slot  <= window_start;
            state      <= sdwq_pkg::ST_IDLE;
          end
        end

        default: begin
          state <= sdwq_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- test/deadline_window_checker.sv -----
`timescale 1ns / 1ps

module deadline_window_checker #(
  parameter int RING_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  sdwq_pkg::slot_t   cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              command,
  input  sdwq_pkg::slot_t   slot_number,
  input  sdwq_pkg::due_t    due_time,
  input  sdwq_pkg::due_t    current_time,
  input  sdwq_pkg::slot_t   scan_cursor,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              found,
  input  sdwq_pkg::slot_t   ready_slot,
  input  logic              overrun,
  input  sdwq_pkg::slot_t   head_slot,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                hits,
  output int                refusals
);
  import sdwq_pkg::*;

  typedef struct packed {
    logic  found;
    slot_t ready_slot;
    logic  overrun;
    slot_t head_slot;
  } outcome_t;

  // Shadow of the window and its ring of deadlines.
  slot_t    watermark;
  slot_t    win_lo;
  slot_t    win_hi;
  due_t     deadlines [RING_DEPTH];
  outcome_t awaited [$];

  int failures      = 0;
  int results_seen  = 0;
  int hit_count     = 0;
  int refusal_count = 0;

  function automatic int ring_idx(slot_t s);
    return int'(s % slot_t'(RING_DEPTH));
  endfunction

  // Insert a deadline; return 1 when the window would outgrow the ring or the slot is SLOT_MAX outside it.
  function automatic logic insert_deadline(slot_t slot, due_t when);
    slot_t k;
    int    i;
    i = ring_idx(slot);
    if (win_lo == win_hi) begin
      if (slot == SLOT_MAX) return 1'b1;
      win_lo = slot;
      win_hi = slot + 1;
      deadlines[i] = when;
    end else if (slot < win_lo) begin
      if (win_hi - slot > slot_t'(RING_DEPTH)) return 1'b1;
      deadlines[i] = when;
      for (k = slot + 1; k < win_lo; k++) deadlines[ring_idx(k)] = '0;
      win_lo = slot;
    end else if (slot >= win_hi) begin
      if (slot == SLOT_MAX || slot - win_lo >= slot_t'(RING_DEPTH)) return 1'b1;
      deadlines[i] = when;
      for (k = win_hi; k < slot; k++) deadlines[ring_idx(k)] = '0;
      win_hi = slot + 1;
    end else begin
      // Keep the earlier of two nonzero deadlines.
      if (deadlines[i] == 0 || deadlines[i] > when) deadlines[i] = when;
    end
    return 1'b0;
  endfunction

  // Find the first slot due by now, popping dead head entries on the way.
  function automatic logic take_due_slot(input due_t now, input slot_t cursor,
                                         output slot_t hit);
    slot_t k;
    int    i;
    hit = '0;
    k = (cursor > win_lo) ? cursor : win_lo;
    while (k < win_hi) begin
      i = ring_idx(k);
      if (k <= watermark || deadlines[i] == 0) begin
        if (win_lo == k) win_lo = k + 1;
      end else if (deadlines[i] <= now) begin
        deadlines[i] = '0;
        if (win_lo == k) win_lo = k + 1;
        hit = k;
        return 1'b1;
      end
      k++;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : track
    outcome_t want;
    outcome_t got;
    slot_t    hit;
    if (rst) begin
      watermark = '0;
      win_lo    = '0;
      win_hi    = '0;
      for (int i = 0; i < RING_DEPTH; i++) deadlines[i] = '0;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {found, ready_slot, overrun, head_slot};
        if (awaited.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("[%0t] result with no request outstanding: found=%0b ready_slot=%0d %s%0d",
                     $time, got.found, got.ready_slot, "head_slot=", got.head_slot);
        end else begin
          want = awaited.pop_front();
          results_seen++;
          if (got.found !== want.found || got.ready_slot !== want.ready_slot ||
              got.overrun !== want.overrun || got.head_slot !== want.head_slot) begin
            failures++;
            if (failures <= 10) begin
              $display("[%0t] mismatch: expected found=%0b ready_slot=%0d overrun=%0b head=%0d",
                       $time, want.found, want.ready_slot, want.overrun, want.head_slot);
              $display("[%0t]           actual   found=%0b ready_slot=%0d overrun=%0b head=%0d",
                       $time, got.found, got.ready_slot, got.overrun, got.head_slot);
            end
          end
        end
      end

      if (cfg_wr_en) watermark = cfg_wr_data;

      if (in_valid && in_ready) begin
        want = '0;
        if (command == CMD_ADD) begin
          want.overrun = insert_deadline(slot_number, due_time);
          if (want.overrun) refusal_count++;
        end else begin
          want.found = take_due_slot(current_time, scan_cursor, hit);
          want.ready_slot = hit;
          if (want.found) hit_count++;
        end
        want.head_slot = win_lo;
        awaited.push_back(want);
      end
    end

    fail_count <= failures;
    pending    <= awaited.size();
    checked    <= results_seen;
    hits       <= hit_count;
    refusals   <= refusal_count;
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sdwq_pkg::*;

  localparam int RING_DEPTH    = 1024;
  // Worst single transaction walks up to the ring depth plus stalls; allow plenty more.
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_OFF      = 600;
  localparam int HOLD_AT       = 250;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 88;
  localparam int TAIL_CYCLES   = 1200;

  logic  clk;
  logic  rst          = 1'b1;
  logic  cfg_wr_en    = 1'b0;
  slot_t cfg_wr_data  = '0;
  logic  in_valid     = 1'b0;
  logic  in_ready;
  logic  command      = CMD_ADD;
  slot_t slot_number  = '0;
  due_t  due_time     = '0;
  due_t  current_time = '0;
  slot_t scan_cursor  = '0;
  logic  out_valid;
  logic  out_ready    = 1'b0;
  logic  found;
  logic  overrun;
  slot_t ready_slot;
  slot_t head_slot;

  int fail_count;
  int pending;
  int checked;
  int hits;
  int refusals;

  int sent     = 0;
  int settings = 0;
  // Calm stretches: no idle cycles on that side.
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;

  slot_deadline_window_queue_core #(
    .RING_DEPTH(RING_DEPTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .slot_number (slot_number),
    .due_time    (due_time),
    .current_time(current_time),
    .scan_cursor (scan_cursor),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .ready_slot  (ready_slot),
    .overrun     (overrun),
    .head_slot   (head_slot)
  );

  deadline_window_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .slot_number (slot_number),
    .due_time    (due_time),
    .current_time(current_time),
    .scan_cursor (scan_cursor),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .ready_slot  (ready_slot),
    .overrun     (overrun),
    .head_slot   (head_slot),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .hits        (hits),
    .refusals    (refusals)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request transaction after a random idle gap; hold it until taken.
  task automatic send_item(input logic cmd, input slot_t slot, input due_t due,
                           input due_t now, input slot_t cursor);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    slot_number  <= slot;
    due_time     <= due;
    current_time <= now;
    scan_cursor  <= cursor;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drop valid and wait until every outstanding result has been drained.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the watermark only while the block is idle.
  task automatic set_watermark(input slot_t value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings++;
  endtask

  // Mostly slots near base and times near t0; some far slots, extremes and noise.
  task automatic random_item(input slot_t base, input due_t t0);
    int    roll;
    logic  cmd;
    slot_t slot;
    slot_t cursor;
    due_t  due;
    due_t  now;
    cmd = ($urandom_range(0, 99) < 55) ? CMD_ADD : CMD_NEXT;

    roll = $urandom_range(0, 99);
    if (roll < 80)      slot = base + slot_t'($urandom_range(0, 48));
    else if (roll < 88) slot = base + slot_t'($urandom_range(990, 1100));
    else if (roll < 93) slot = base - slot_t'($urandom_range(1, 40));
    else if (roll < 98) slot = {$urandom, $urandom};
    else                slot = SLOT_MAX;

    roll = $urandom_range(0, 99);
    if (roll < 70)      due = t0 + due_t'($urandom_range(0, 200)) - 100;
    else if (roll < 80) due = '0;
    else if (roll < 85) due = {1'b1, 63'd0};
    else if (roll < 90) due = {1'b0, {63{1'b1}}};
    else                due = {$urandom, $urandom};

    roll = $urandom_range(0, 99);
    if (roll < 60)      now = t0 + due_t'($urandom_range(0, 200)) - 100;
    else if (roll < 75) now = {1'b0, {63{1'b1}}};
    else if (roll < 85) now = {1'b1, 63'd0};
    else                now = {$urandom, $urandom};

    roll = $urandom_range(0, 99);
    if (roll < 40)      cursor = '0;
    else if (roll < 80) cursor = base + slot_t'($urandom_range(0, 60));
    else if (roll < 90) cursor = {$urandom, $urandom};
    else                cursor = SLOT_MAX;

    send_item(cmd, slot, due, now, cursor);
  endtask

  // Stimulus: directed corners, then phases of random traffic per watermark.
  initial begin : stimulus
    slot_t b;
    slot_t base;
    due_t  t0;
    due_t  t_max;
    due_t  t_min;
    b     = 64'd5000;
    t_max = {1'b0, {63{1'b1}}};
    t_min = {1'b1, 63'd0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_watermark('0);

    // Empty window: nothing to find, top slot refused.
    send_item(CMD_NEXT, '0, '0, '0, '0);
    send_item(CMD_ADD, SLOT_MAX, 64'sd10, '0, '0);
    // Start a window, then keep the earlier deadline of the same slot.
    send_item(CMD_ADD, b, 64'sd50, '0, '0);
    send_item(CMD_ADD, b, 64'sd70, '0, '0);
    send_item(CMD_ADD, b, 64'sd30, '0, '0);
    // Grow down with a zero deadline, grow up, fill inside at both extremes.
    send_item(CMD_ADD, b - 2, '0, '0, '0);
    send_item(CMD_ADD, b + 3, -64'sd5, '0, '0);
    send_item(CMD_ADD, b + 1, t_min, '0, '0);
    send_item(CMD_ADD, b + 2, t_max, '0, '0);
    // Grow up: one past the ring depth is refused, exactly the depth fits.
    send_item(CMD_ADD, b + 1022, 64'sd7, '0, '0);
    send_item(CMD_ADD, b + 1021, 64'sd7, '0, '0);
    // Grow down past the ring depth.
    send_item(CMD_ADD, b - 3, 64'sd7, '0, '0);
    // Cursor past the window; then finds at the lowest time and in order.
    send_item(CMD_NEXT, '0, '0, t_max, SLOT_MAX);
    send_item(CMD_NEXT, '0, '0, t_min, '0);
    send_item(CMD_NEXT, '0, '0, 64'sd29, b);
    send_item(CMD_NEXT, '0, '0, 64'sd30, '0);
    send_item(CMD_NEXT, '0, '0, t_max, '0);
    // Watermark over the whole window: everything is popped.
    set_watermark(b + 1021);
    send_item(CMD_NEXT, '0, '0, t_max, '0);
    set_watermark('0);
    // Grow down to exactly the ring depth, then scan from a cursor inside.
    send_item(CMD_ADD, b + 5000, 64'sd1, '0, '0);
    send_item(CMD_ADD, b + 3977, 64'sd2, '0, '0);
    send_item(CMD_NEXT, '0, '0, t_max, b + 4500);
    set_watermark(SLOT_MAX);
    send_item(CMD_NEXT, '0, '0, t_max, '0);
    set_watermark('0);
    // Top slot outside a window that ends just below it.
    send_item(CMD_ADD, SLOT_MAX - 1, 64'sd3, '0, '0);
    send_item(CMD_ADD, SLOT_MAX, 64'sd3, '0, '0);
    send_item(CMD_NEXT, '0, '0, t_max, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0:       base = slot_t'(3000 + $urandom_range(0, 1000));
        1:       base = {$urandom, $urandom};
        2:       base = SLOT_MAX - 60;
        default: base = 64'h8000_0000_0000_0000 - 30;
      endcase
      case (p % 3)
        0:       t0 = '0;
        1:       t0 = {$urandom, $urandom};
        default: t0 = -64'sd1000;
      endcase

      // Flush the old window so the new base is reachable.
      set_watermark(SLOT_MAX);
      send_item(CMD_NEXT, '0, '0, t_max, '0);

      case (p)
        0:       set_watermark('0);
        1:       set_watermark(base + slot_t'($urandom_range(0, 30)));
        2:       set_watermark({$urandom, $urandom});
        3:       set_watermark(SLOT_MAX);
        4:       set_watermark(base - 1);
        6:       set_watermark(base + 40);
        default: set_watermark('0);
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        random_item(base, t0);
        t0 = t0 + 1;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d requests sent, %0d results checked, %0d due slots found, %0d adds refused",
             sent, checked, hits, refusals);
    $display("tb: %0d watermark settings, one receiver hold-off of %0d cycles",
             settings, HOLD_OFF);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches, and one long hold-off that backs up the input.
  initial begin : drain
    int gap;
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && taken == HOLD_AT) begin
        gap  = HOLD_OFF;
        held = 1'b1;
      end else begin
        gap = receiver_calm ? 0 : $urandom_range(0, 17);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
